/* hw/rtl/lwv_pkg.sv */
// lwv_pkg: shared types and constants of the local window variance block
// no dependencies; imported by the controller, the datapath, the top level and the checker

package lwv_pkg;

   // position arithmetic width: holds rows and columns up to 4096 plus radius, with a sign
   localparam int POS_W = 14;
   localparam int VAR_W = 22;
   localparam int CTR_W = 10;

   localparam int RADIUS_W = 2;
   localparam int DIM_W    = 11;
   localparam int ADDR_W_CSR = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_RADIUS = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [RADIUS_W-1:0] RADIUS_RST = 2'd1;
   localparam logic [DIM_W-1:0]    WIDTH_RST  = 11'd640;
   localparam logic [DIM_W-1:0]    HEIGHT_RST = 11'd480;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef struct packed {
      logic accept;
      logic start_win;
      logic issue;
      logic mul;
      logic sub;
      logic div_step;
      logic load_out;
      logic next_col;
   } cmd_type;

   typedef struct packed {
      logic item_go;
      logic win_last;
      logic div_last;
      logic more_cols;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/lwv_ctrl.sv */
// lwv_ctrl: sequencer for one input beat and the windows it produces
// depends on lwv_pkg for the command and status structs

module lwv_ctrl
   import lwv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CALC = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_SUB  = 3'd4;
   localparam logic [2:0] ST_DIV  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.item_go) begin
                  cmd.start_win = 1'b1;
                  state_in      = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cmd.issue = 1'b1;
            if (status.win_last) state_in = ST_WAIT;
         end
         ST_WAIT: state_in = ST_MUL;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.sub  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.more_cols) begin
                  cmd.next_col  = 1'b1;
                  cmd.start_win = 1'b1;
                  state_in      = ST_CALC;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/lwv_dp.sv */
// lwv_dp: positions, line store, window accumulation, divider and result register
// depends on lwv_pkg; driven by lwv_ctrl through cmd_type

module lwv_dp
   import lwv_pkg::*;
#(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                restart,
   input  logic [RADIUS_W-1:0] radius,
   input  logic [DIM_W-1:0]    image_width,
   input  logic [DIM_W-1:0]    image_height,
   input  logic                req_func,
   input  logic [7:0]          req_pixel,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VAR_W-1:0]    rsp_variance_q8,
   output logic [CTR_W-1:0]    rsp_center_row,
   output logic [CTR_W-1:0]    rsp_center_col,
   output logic                rsp_last_of_run,
   output logic                rsp_last_of_frame
);

   localparam int SLOTS  = 2 * MAX_RADIUS + 1;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int DEPTH  = SLOTS * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NMAX   = SLOTS * SLOTS;
   localparam int N_W    = $clog2(NMAX + 1);
   localparam int S_W    = $clog2(NMAX * 255 + 1);
   localparam int Q_W    = $clog2(NMAX * 65025 + 1);
   localparam int NUM_W  = N_W + Q_W;
   localparam int DIVW   = NUM_W + 8;
   localparam int N2_W   = 2 * N_W;
   localparam int DC_W   = $clog2(DIVW);
   localparam int OFF_W  = $clog2(MAX_RADIUS + 1) + 1;

   // effective geometry
   logic [POS_W-1:0] w, h, r, rmax;
   always_comb begin
      w = POS_W'(image_width);
      if (image_width == '0) w = POS_W'(1);
      else if (POS_W'(image_width) > POS_W'(MAX_WIDTH)) w = POS_W'(MAX_WIDTH);
      h = POS_W'(image_height);
      if (image_height == '0) h = POS_W'(1);
      else if (POS_W'(image_height) > POS_W'(MAX_HEIGHT)) h = POS_W'(MAX_HEIGHT);
      r = POS_W'(radius);
      rmax = POS_W'(MAX_RADIUS);
      if (r > rmax) r = rmax;
      if (r > w - POS_W'(1)) r = w - POS_W'(1);
      if (r > h - POS_W'(1)) r = h - POS_W'(1);
   end

   logic [POS_W-1:0]  row_ff, col_ff;
   logic [SLOT_W-1:0] slot_ff;

   // decode of the beat on offer
   logic [POS_W-1:0]  v, x, c0, c1;
   logic [SLOT_W-1:0] vslot;
   logic              wrap, item_ok, item_has, x_last;
   always_comb begin
      wrap  = (row_ff >= h + r) || (col_ff >= w);
      v     = wrap ? '0 : row_ff;
      x     = wrap ? '0 : col_ff;
      vslot = wrap ? '0 : slot_ff;
      x_last  = (x == w - POS_W'(1));
      item_ok = (v < h) ? (req_func == FUNC_PIXEL) : (req_func == FUNC_DRAIN);
      item_has = item_ok && (v >= r) && (x_last || x >= r);
      c0 = x - r;
      c1 = x_last ? w - POS_W'(1) : x - r;
   end

   // cursor of the window being worked on
   logic [POS_W-1:0]  cy_ff, v_ff, c_ff, c1_ff;
   logic [SLOT_W-1:0] vslot_ff;
   logic [N_W-1:0]    n_ff;
   logic signed [OFF_W-1:0] dy_ff, dx_ff;
   logic [OFF_W-1:0]  r_off;
   assign r_off = OFF_W'(r);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (cmd.accept && item_ok) begin
         if (x + POS_W'(1) >= w) begin
            col_ff <= '0;
            if (v + POS_W'(1) >= h + r) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= v + POS_W'(1);
               slot_ff <= (vslot == SLOT_W'(SLOTS - 1)) ? '0 : vslot + SLOT_W'(1);
            end
         end else begin
            col_ff  <= x + POS_W'(1);
            row_ff  <= v;
            slot_ff <= vslot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cy_ff    <= v - r;
         v_ff     <= v;
         vslot_ff <= vslot;
         c_ff     <= c0;
         c1_ff    <= c1;
         n_ff     <= N_W'((2 * r + POS_W'(1)) * (2 * r + POS_W'(1)));
      end else if (cmd.next_col) begin
         c_ff <= c_ff + POS_W'(1);
      end
      if (cmd.start_win) begin
         dy_ff <= -$signed(r_off);
         dx_ff <= -$signed(r_off);
      end else if (cmd.issue) begin
         if (dx_ff == $signed(r_off)) begin
            dx_ff <= -$signed(r_off);
            dy_ff <= dy_ff + OFF_W'(1);
         end else begin
            dx_ff <= dx_ff + OFF_W'(1);
         end
      end
   end

   // clamped sample address
   logic [POS_W-1:0]   yy_raw, xx_raw, yy, xx, k;
   logic [SLOT_W:0]    k1, vs1, rslot1;
   logic [SLOT_W-1:0]  rslot;
   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   always_comb begin
      yy_raw = cy_ff + POS_W'(dy_ff);
      xx_raw = c_ff + POS_W'(dx_ff);
      if (yy_raw[POS_W-1]) yy = '0;
      else if (yy_raw > h - POS_W'(1)) yy = h - POS_W'(1);
      else yy = yy_raw;
      if (xx_raw[POS_W-1]) xx = '0;
      else if (xx_raw > w - POS_W'(1)) xx = w - POS_W'(1);
      else xx = xx_raw;
      // row distance back from the newest row is at most 2r, below the slot count
      k   = v_ff - yy;
      k1  = (SLOT_W + 1)'(k);
      vs1 = (SLOT_W + 1)'(vslot_ff);
      rslot1 = (vs1 >= k1) ? vs1 - k1 : vs1 + (SLOT_W + 1)'(SLOTS) - k1;
      rslot  = rslot1[SLOT_W-1:0];
      rd_addr = ADDR_W'(rslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xx);
      wr_addr = ADDR_W'(vslot) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
   end

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;
   logic       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && item_ok && (v < h)) mem[wr_addr] <= req_pixel;
      if (cmd.issue) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) rd_vld_ff <= 1'b0;
      else       rd_vld_ff <= cmd.issue;
   end

   // sums and moments
   logic [S_W-1:0]   s_ff;
   logic [Q_W-1:0]   q_ff;
   logic [NUM_W-1:0] nq_ff;
   logic [2*S_W-1:0] ss_ff;
   logic [N2_W-1:0]  n2_ff;
   logic [15:0]      sq;
   assign sq = rdata_ff * rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_win) begin
         s_ff <= '0;
         q_ff <= '0;
      end else if (rd_vld_ff) begin
         s_ff <= s_ff + S_W'(rdata_ff);
         q_ff <= q_ff + Q_W'(sq);
      end
      if (cmd.mul) begin
         nq_ff <= NUM_W'(n_ff) * NUM_W'(q_ff);
         ss_ff <= s_ff * s_ff;
         n2_ff <= n_ff * n_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [DIVW-1:0] quo_ff;
   logic [N2_W:0]   rem_ff, trial;
   logic [DC_W-1:0] dcnt_ff;
   logic [NUM_W-1:0] num;
   assign num   = nq_ff - NUM_W'(ss_ff);
   assign trial = {rem_ff[N2_W-1:0], quo_ff[DIVW-1]};

   always_ff @(posedge clock) begin
      if (cmd.sub) begin
         quo_ff  <= {num, 8'd0};
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DC_W'(1);
         if (trial >= (N2_W + 1)'(n2_ff)) begin
            rem_ff <= trial - (N2_W + 1)'(n2_ff);
            quo_ff <= {quo_ff[DIVW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[DIVW-2:0], 1'b0};
         end
      end
   end

   // result register
   logic out_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_variance_q8   <= quo_ff[VAR_W-1:0];
         rsp_center_row    <= cy_ff[CTR_W-1:0];
         rsp_center_col    <= c_ff[CTR_W-1:0];
         rsp_last_of_run   <= (c_ff == c1_ff);
         rsp_last_of_frame <= (cy_ff == h - POS_W'(1)) && (c_ff == w - POS_W'(1));
      end
   end

   assign rsp_valid = out_vld_ff;

   always_comb begin
      status.item_go   = item_has;
      status.win_last  = (dy_ff == $signed(r_off)) && (dx_ff == $signed(r_off));
      status.div_last  = (dcnt_ff == DC_W'(DIVW - 1));
      status.more_cols = (c_ff != c1_ff);
      status.out_free  = !out_vld_ff || !rsp_stall;
   end

endmodule

/* hw/rtl/local_window_variance_top.sv */
// local_window_variance_top: register port and assembly of controller and datapath
// depends on lwv_pkg, lwv_ctrl and lwv_dp

// Local window variance over a raster 8-bit frame, edges replicated. Each window result
// takes (2r+1)^2 line store reads, one per cycle from the single store port, then the
// products and the one-bit-per-cycle division by n squared over the dividend width (36
// bits at the default sizes); a pixel that causes no result does not stall the input,
// and the row end beat yields r+1 results in turn. A write to the radius, width or height
// register restarts the frame. After the frame, send r*width drain beats (func = 1).

module local_window_variance_top
   import lwv_pkg::*;
#(
   parameter int MAX_RADIUS = 3,
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [7:0]            req_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VAR_W-1:0]      rsp_variance_q8,
   output logic [CTR_W-1:0]      rsp_center_row,
   output logic [CTR_W-1:0]      rsp_center_col,
   output logic                  rsp_last_of_run,
   output logic                  rsp_last_of_frame,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [ADDR_W_CSR-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   logic [RADIUS_W-1:0] radius_ff;
   logic [DIM_W-1:0]    width_ff, height_ff;
   logic                wr_en, restart;
   logic [1:0]          idx;

   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign restart = wr_en && (idx == REG_RADIUS || idx == REG_WIDTH || idx == REG_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
      end else if (wr_en) begin
         case (idx)
            REG_RADIUS: radius_ff <= pwdata[RADIUS_W-1:0];
            REG_WIDTH:  width_ff  <= pwdata[DIM_W-1:0];
            REG_HEIGHT: height_ff <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_RADIUS: prdata = DATA_W'(radius_ff);
         REG_WIDTH:  prdata = DATA_W'(width_ff);
         REG_HEIGHT: prdata = DATA_W'(height_ff);
         default:    prdata = '0;
      endcase
   end

   cmd_type    cmd;
   status_type status;

   lwv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lwv_dp #(
      .MAX_RADIUS (MAX_RADIUS),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .restart           (restart),
      .radius            (radius_ff),
      .image_width       (width_ff),
      .image_height      (height_ff),
      .req_func          (req_func),
      .req_pixel         (req_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_variance_q8   (rsp_variance_q8),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_last_of_run   (rsp_last_of_run),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

/* hw/rtl/lwv_checker.sv */
// lwv_checker: port-level assertions for the local window variance block
// depends on lwv_pkg; bound to local_window_variance_top below

module lwv_checker
   import lwv_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [VAR_W-1:0] rsp_variance_q8,
   input logic             rsp_last_of_run,
   input logic             rsp_last_of_frame
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_frame |-> rsp_last_of_run)
      else $error("frame end not at end of run");

   a_busy_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> req_stall)
      else $error("input taken in the middle of a run");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_variance_q8 <= VAR_W'(4161600))
      else $error("variance out of range");

endmodule

bind local_window_variance_top lwv_checker u_lwv_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_variance_q8   (rsp_variance_q8),
   .rsp_last_of_run   (rsp_last_of_run),
   .rsp_last_of_frame (rsp_last_of_frame)
);
